FILE: rtl/nclc_pkg.sv
// nclc_pkg: types and constant tables for the news command line checker
// no dependencies; used by nclc_decode and news_command_line_checker
`default_nettype none

package nclc_pkg;

    localparam int WORD_COUNT = 7;

    // parse phase of the current line
    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_NAME  = 2'd1,
        PH_GAP   = 2'd2,
        PH_PARAM = 2'd3
    } phase_t;

    // command codes
    typedef enum logic [2:0] {
        CODE_LIST      = 3'd0,
        CODE_QUIT      = 3'd1,
        CODE_LISTGROUP = 3'd2,
        CODE_ARTICLE   = 3'd3,
        CODE_STAT      = 3'd4,
        CODE_HEAD      = 3'd5,
        CODE_BODY      = 3'd6,
        CODE_UNKNOWN   = 3'd7
    } code_t;

    localparam logic [3:0] NAME_LEN_MAX = 4'd15;
    localparam logic [7:0] CHAR_AT      = 8'h40;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;
    localparam logic [7:0] CHAR_LOW_A   = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z   = 8'h7A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;

    // command words, first letter at index 0, zero padded to 16 bytes
    localparam logic [0:WORD_COUNT-1][0:15][7:0] WORD_TEXT = {
        {"LIST",      96'h0},
        {"QUIT",      96'h0},
        {"LISTGROUP", 56'h0},
        {"ARTICLE",   72'h0},
        {"STAT",      96'h0},
        {"HEAD",      96'h0},
        {"BODY",      96'h0}
    };

    localparam logic [0:WORD_COUNT-1][3:0] WORD_LEN = {
        4'd4, 4'd4, 4'd9, 4'd7, 4'd4, 4'd4, 4'd4
    };

    // per-line parse state
    typedef struct packed {
        phase_t                  phase;
        logic [WORD_COUNT-1:0]   match;
        logic [3:0]              name_len;
        logic                    param_seen;
        logic                    at_seen;
    } state_t;

    localparam state_t STATE_RESET = '{
        phase:      PH_LEAD,
        match:      {WORD_COUNT{1'b1}},
        name_len:   4'd0,
        param_seen: 1'b0,
        at_seen:    1'b0
    };

    // one result item
    typedef struct packed {
        logic  syntax_ok;
        code_t code;
        logic  has_param;
        logic  id_ok;
        logic  quit;
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/nclc_decode.sv
// nclc_decode: next parse state and line result for one input byte
// depends on nclc_pkg
`default_nettype none

module nclc_decode (
    input  wire nclc_pkg::state_t  state_cur,
    input  wire logic [7:0]        ch,
    input  wire logic              has_char,
    input  wire logic              last,
    output nclc_pkg::state_t       state_next,
    output nclc_pkg::result_t      result
);

    logic             is_ws;
    logic [7:0]       ch_upper;
    nclc_pkg::state_t upd;
    nclc_pkg::state_t named;
    nclc_pkg::code_t  code;

    // whitespace and upper-casing
    always_comb begin
        is_ws = (ch == nclc_pkg::CHAR_SPACE) ||
                ((ch >= nclc_pkg::CHAR_TAB) && (ch <= nclc_pkg::CHAR_CR));
        if ((ch >= nclc_pkg::CHAR_LOW_A) && (ch <= nclc_pkg::CHAR_LOW_Z)) begin
            ch_upper = ch - nclc_pkg::CASE_OFFSET;
        end else begin
            ch_upper = ch;
        end
    end

    // state after taking this byte as a name byte
    always_comb begin
        named = state_cur;
        named.phase = nclc_pkg::PH_NAME;
        for (int w = 0; w < nclc_pkg::WORD_COUNT; w++) begin
            if ((state_cur.name_len >= nclc_pkg::WORD_LEN[w]) ||
                (nclc_pkg::WORD_TEXT[w][state_cur.name_len] != ch_upper)) begin
                named.match[w] = 1'b0;
            end
        end
        if (state_cur.name_len != nclc_pkg::NAME_LEN_MAX) begin
            named.name_len = state_cur.name_len + 4'd1;
        end
    end

    // phase stepping
    always_comb begin
        upd = state_cur;
        if (has_char) begin
            unique case (state_cur.phase)
                nclc_pkg::PH_LEAD: begin
                    if (!is_ws) upd = named;
                end
                nclc_pkg::PH_NAME: begin
                    if (is_ws) upd.phase = nclc_pkg::PH_GAP;
                    else       upd = named;
                end
                nclc_pkg::PH_GAP: begin
                    if (!is_ws) begin
                        upd.phase      = nclc_pkg::PH_PARAM;
                        upd.param_seen = 1'b1;
                        if (ch == nclc_pkg::CHAR_AT) upd.at_seen = 1'b1;
                    end
                end
                nclc_pkg::PH_PARAM: begin
                    upd.param_seen = 1'b1;
                    if (ch == nclc_pkg::CHAR_AT) upd.at_seen = 1'b1;
                end
                default: upd = state_cur;
            endcase
        end
        state_next = last ? nclc_pkg::STATE_RESET : upd;
    end

    // word lookup, lowest index wins
    always_comb begin
        code = nclc_pkg::CODE_UNKNOWN;
        for (int w = nclc_pkg::WORD_COUNT - 1; w >= 0; w--) begin
            if (upd.match[w] && (upd.name_len == nclc_pkg::WORD_LEN[w])) begin
                code = nclc_pkg::code_t'(w[2:0]);
            end
        end
    end

    // result fields
    always_comb begin
        result.code      = code;
        result.has_param = upd.param_seen;
        result.quit      = (code == nclc_pkg::CODE_QUIT);
        if (code == nclc_pkg::CODE_UNKNOWN) begin
            result.syntax_ok = 1'b0;
        end else if (code == nclc_pkg::CODE_QUIT) begin
            result.syntax_ok = !upd.param_seen;
        end else begin
            result.syntax_ok = upd.param_seen;
        end
        if ((code == nclc_pkg::CODE_ARTICLE) || (code == nclc_pkg::CODE_STAT) ||
            (code == nclc_pkg::CODE_HEAD) || (code == nclc_pkg::CODE_BODY)) begin
            result.id_ok = upd.at_seen;
        end else begin
            result.id_ok = 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/news_command_line_checker.sv
// news_command_line_checker: one byte per cycle unless stalled; the result of a line is in the
// output register in the cycle after the byte marked last is accepted
// throughput one item per cycle; any item stalls while a result waits unread,
// limited by the single output register
// aresetn (synchronous, active low) returns the parse state to the start of a
// line and empties the output register
`default_nettype none

module news_command_line_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_ch,
    input  wire logic       s_has_char,
    input  wire logic       s_last,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic            m_syntax_ok,
    output logic [2:0]      m_command_code,
    output logic            m_has_parameter,
    output logic            m_id_check_ok,
    output logic            m_quit
);

    nclc_pkg::state_t  state_reg;
    nclc_pkg::state_t  state_next;
    nclc_pkg::result_t result_next;
    nclc_pkg::result_t result_reg;
    logic              m_valid_reg;
    logic              s_accept;
    nclc_pkg::state_t  state_cur_w;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    assign state_cur_w = state_reg;

    nclc_decode u_decode (
        .state_cur  (state_cur_w),
        .ch         (s_ch),
        .has_char   (s_has_char),
        .last       (s_last),
        .state_next (state_next),
        .result     (result_next)
    );

    // parse state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nclc_pkg::STATE_RESET;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // output register valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_accept && s_last) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge aclk) begin
        if (s_accept && s_last) begin
            result_reg <= result_next;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_syntax_ok     = result_reg.syntax_ok;
    assign m_command_code  = result_reg.code;
    assign m_has_parameter = result_reg.has_param;
    assign m_id_check_ok   = result_reg.id_ok;
    assign m_quit          = result_reg.quit;

`ifndef SYNTH
    // a line end always yields a result next cycle
    a_last_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last |=> m_valid)
        else $error("line end did not produce a result");

    // parse state restarts after a line end
    a_state_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept && s_last |=> (state_reg == nclc_pkg::STATE_RESET))
        else $error("parse state not cleared after line end");

    // a waiting result is not disturbed by mid-line bytes
    a_result_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && s_accept && !s_last |=> m_valid && $stable(result_reg))
        else $error("waiting result changed");

    // quit flag agrees with the code
    a_quit_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_quit == (m_command_code == nclc_pkg::CODE_QUIT)))
        else $error("quit flag disagrees with command code");
`endif

endmodule

`default_nettype wire

FILE: dv/news_command_line_checker_tb.sv
`timescale 1ns / 1ps
// news_command_line_checker_tb: self-checking testbench for the news command line checker
// depends on nclc_pkg (phase, code and result types) and the news_command_line_checker rtl

module news_command_line_checker_tb;

    typedef logic [7:0] text_t[$];

    localparam logic [7:0] AT_SIGN    = 8'h40;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam int         LINE_ITEMS = 1100;

    // line parser prediction and expected verdict queue
    class cmd_line_scoreboard;
        string               words[7];
        nclc_pkg::phase_t    phase;
        logic [6:0]          prefix_live;
        logic [3:0]          name_len;
        bit                  param_seen;
        bit                  at_seen;
        nclc_pkg::result_t   verdict_q[$];
        int                  errors;

        function new();
            words = '{"LIST", "QUIT", "LISTGROUP", "ARTICLE", "STAT", "HEAD", "BODY"};
            errors = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase       = nclc_pkg::PH_LEAD;
            prefix_live = '1;
            name_len    = 4'd0;
            param_seen  = 1'b0;
            at_seen     = 1'b0;
        endfunction

        function bit is_blank(logic [7:0] c);
            return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
        endfunction

        // upper-case a..z, then drop every word the name no longer prefixes
        function void take_name_char(logic [7:0] c);
            logic [7:0] u;
            u = (c >= "a" && c <= "z") ? c - 8'h20 : c;
            for (int w = 0; w < 7; w++) begin
                if (name_len >= words[w].len() || words[w][name_len] != u)
                    prefix_live[w] = 1'b0;
            end
            if (name_len != 4'hF)
                name_len++;
        endfunction

        function void note_input(logic [7:0] ch, bit has_char, bit last);
            nclc_pkg::result_t r;
            nclc_pkg::code_t   code;
            if (has_char) begin
                case (phase)
                    nclc_pkg::PH_LEAD: begin
                        if (!is_blank(ch)) begin
                            phase = nclc_pkg::PH_NAME;
                            take_name_char(ch);
                        end
                    end
                    nclc_pkg::PH_NAME: begin
                        if (is_blank(ch))
                            phase = nclc_pkg::PH_GAP;
                        else
                            take_name_char(ch);
                    end
                    nclc_pkg::PH_GAP: begin
                        if (!is_blank(ch)) begin
                            phase      = nclc_pkg::PH_PARAM;
                            param_seen = 1'b1;
                            if (ch == AT_SIGN)
                                at_seen = 1'b1;
                        end
                    end
                    default: begin
                        param_seen = 1'b1;
                        if (ch == AT_SIGN)
                            at_seen = 1'b1;
                    end
                endcase
            end
            if (!last)
                return;
            // first live word of exactly the name length
            code = nclc_pkg::CODE_UNKNOWN;
            for (int w = 0; w < 7; w++) begin
                if (code == nclc_pkg::CODE_UNKNOWN && prefix_live[w] &&
                    name_len == words[w].len())
                    code = nclc_pkg::code_t'(w);
            end
            r.code      = code;
            r.has_param = param_seen;
            if (code == nclc_pkg::CODE_UNKNOWN)
                r.syntax_ok = 1'b0;
            else if (code == nclc_pkg::CODE_QUIT)
                r.syntax_ok = !param_seen;
            else
                r.syntax_ok = param_seen;
            r.id_ok = (code >= nclc_pkg::CODE_ARTICLE && code <= nclc_pkg::CODE_BODY) ?
                      at_seen : 1'b1;
            r.quit  = (code == nclc_pkg::CODE_QUIT);
            verdict_q.push_back(r);
            clear_line();
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            errors++;
        endtask

        task check_result(nclc_pkg::result_t got);
            nclc_pkg::result_t want;
            if (verdict_q.size() == 0) begin
                report("result with no line pending");
                return;
            end
            want = verdict_q.pop_front();
            if (got.syntax_ok !== want.syntax_ok)
                report($sformatf("syntax_ok %0b, expected %0b", got.syntax_ok, want.syntax_ok));
            if (got.code !== want.code)
                report($sformatf("command_code %0d, expected %0d", got.code, want.code));
            if (got.has_param !== want.has_param)
                report($sformatf("has_parameter %0b, expected %0b", got.has_param,
                                 want.has_param));
            if (got.id_ok !== want.id_ok)
                report($sformatf("id_check_ok %0b, expected %0b", got.id_ok, want.id_ok));
            if (got.quit !== want.quit)
                report($sformatf("quit %0b, expected %0b", got.quit, want.quit));
        endtask

        function int pending();
            return verdict_q.size();
        endfunction
    endclass

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch = 8'h00;
    logic       s_has_char = 1'b0;
    logic       s_last = 1'b0;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_syntax_ok;
    logic [2:0] m_command_code;
    logic       m_has_parameter;
    logic       m_id_check_ok;
    logic       m_quit;

    cmd_line_scoreboard sb = new();

    logic [7:0] blank_chars[6] = '{8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    int         burst_left = 0;
    bit         calm = 1'b0;
    int         items_sent = 0;
    int         rx_cycle = 0;
    int         rx_mode = 0;
    logic [7:0] rx_mask = 8'b1011_0010;

    news_command_line_checker DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_ch            (s_ch),
        .s_has_char      (s_has_char),
        .s_last          (s_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_syntax_ok     (m_syntax_ok),
        .m_command_code  (m_command_code),
        .m_has_parameter (m_has_parameter),
        .m_id_check_ok   (m_id_check_ok),
        .m_quit          (m_quit)
    );

    // clock
    initial begin
        forever #10 aclk = ~aclk;
    end

    // run limit
    initial begin
        #10_000_000;
        $display("FAIL news_command_line_checker");
        $finish;
    end

    // result monitor
    always @(posedge aclk) begin
        nclc_pkg::result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.syntax_ok = m_syntax_ok;
            got.code      = nclc_pkg::code_t'(m_command_code);
            got.has_param = m_has_parameter;
            got.id_ok     = m_id_check_ok;
            got.quit      = m_quit;
            sb.check_result(got);
        end
    end

    // receiver stalls: m_ready follows one of four modes, redrawn periodically
    initial begin
        forever begin
            @(negedge aclk);
            rx_cycle++;
            if (rx_cycle % 150 == 0) begin
                rx_mode = $urandom_range(0, 3);
                rx_mask = 8'($urandom_range(1, 255));
            end
            case (rx_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= rx_mask[rx_cycle % 8];
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic text_t to_text(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    function automatic logic [7:0] pick_blank();
        return blank_chars[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [7:0] random_nonblank();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (sb.is_blank(c));
        return c;
    endfunction

    // mostly well formed lines, names sometimes mutated; some noise and blank lines
    function automatic text_t build_line();
        text_t      t;
        text_t      nm;
        int         kind;
        int         n;
        int         at_pos;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            n = $urandom_range(0, 12);
            repeat (n) t.push_back(8'($urandom_range(0, 255)));
            return t;
        end
        if (kind == 1) begin
            n = $urandom_range(0, 4);
            repeat (n) t.push_back(pick_blank());
            return t;
        end
        repeat ($urandom_range(0, 2)) t.push_back(pick_blank());
        // command name, possibly truncated, extended, corrupted or replaced
        nm = to_text(sb.words[$urandom_range(0, 6)]);
        case ($urandom_range(0, 9))
            0: nm = nm[0:$urandom_range(0, nm.size() - 2)];
            1: repeat ($urandom_range(1, 8)) nm.push_back(random_letter());
            2: nm[$urandom_range(0, nm.size() - 1)] = random_nonblank();
            3: begin
                nm.delete();
                repeat ($urandom_range(1, 18)) nm.push_back(random_letter());
            end
            default: ;
        endcase
        foreach (nm[i]) begin
            if (nm[i] >= "A" && nm[i] <= "Z" && $urandom_range(0, 1))
                nm[i] = nm[i] + 8'h20;
            t.push_back(nm[i]);
        end
        // gap and parameter
        if ($urandom_range(0, 9) < 7) begin
            repeat ($urandom_range(1, 3)) t.push_back(pick_blank());
            n = $urandom_range(1, 10);
            at_pos = $urandom_range(0, 1) ? int'($urandom_range(0, n - 1)) : -1;
            for (int i = 0; i < n; i++) begin
                if (i == at_pos)
                    c = AT_SIGN;
                else if (i == 0)
                    c = random_nonblank();
                else if ($urandom_range(0, 3) == 0)
                    c = 8'($urandom_range(0, 255));
                else
                    c = 8'($urandom_range(8'h21, 8'h7E));
                t.push_back(c);
            end
            if ($urandom_range(0, 2) == 0)
                repeat ($urandom_range(1, 3)) t.push_back(SPACE_CHAR);
        end else begin
            repeat ($urandom_range(0, 2)) t.push_back(pick_blank());
        end
        return t;
    endfunction

    // one item, with burst and gap pacing on the sender side
    task automatic send_item(logic [7:0] ch, bit has_char, bit last);
        int gap;
        if (burst_left == 0) begin
            gap = calm ? 0 : $urandom_range(1, 6);
            repeat (gap) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge aclk);
        s_valid    <= 1'b1;
        s_ch       <= ch;
        s_has_char <= has_char;
        s_last     <= last;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(ch, has_char, last);
        if (has_char || last)
            items_sent++;
    endtask

    // a line ends on its last byte or on a separate end item without a byte
    task automatic send_line(text_t t, bit close_empty);
        foreach (t[i]) begin
            if ($urandom_range(0, 11) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(t[i], 1'b1, !close_empty && i == t.size() - 1);
        end
        if (close_empty || t.size() == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial begin
        text_t t;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: idle step, empty line, mixed case quit, id with '@',
        // NUL and 0xff as name bytes, name followed only by whitespace
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_line(to_text("\tqUIt"), 1'b0);
        send_line(to_text("STAT @"), 1'b0);
        t = '{8'h00, 8'hFF};
        send_line(t, 1'b0);
        send_line(to_text("HEAD\r"), 1'b1);

        // random lines
        while (items_sent < LINE_ITEMS) begin
            if ($urandom_range(0, 39) == 0)
                calm = !calm;
            t = build_line();
            send_line(t, $urandom_range(0, 3) == 0);
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0)
            $display("PASS news_command_line_checker");
        else
            $display("FAIL news_command_line_checker");
        $finish;
    end

endmodule
